// File: rtl/core/g6enc_pkg.sv
// g6enc_pkg: item types, stage codes and character constants for the graph6 encoder
// no dependencies; used by graph6_encoder_unit
`default_nettype none

package g6enc_pkg;

  localparam int unsigned ROW_DEPTH    = 64;
  localparam int unsigned ROW_WIDTH    = 64;
  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned GROUP_BITS   = 6;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [2:0] STAGE_HDR0    = 3'd0;
  localparam logic [2:0] STAGE_GRP_HI  = 3'd1;
  localparam logic [2:0] STAGE_GRP_MID = 3'd2;
  localparam logic [2:0] STAGE_GRP_LO  = 3'd3;
  localparam logic [2:0] STAGE_DATA    = 3'd4;

  localparam logic [6:0] SHORT_N_MAX  = 7'd62;
  localparam logic [6:0] CHAR_OFFSET  = 7'd63;
  localparam logic [6:0] CHAR_TILDE   = 7'd126;
  localparam logic [6:0] CHAR_NEWLINE = 7'd10;

  typedef struct packed {
    logic        command;
    logic [5:0]  row_addr;
    logic [63:0] row_bits;
  } g6enc_in_t;

  typedef struct packed {
    logic [6:0] out_byte;
    logic       last_byte;
  } g6enc_out_t;

endpackage

`default_nettype wire

// File: rtl/core/graph6_encoder_unit.sv
// graph6_encoder_unit: adjacency row store and graph6 character generator
// depends on g6enc_pkg for item types and constants
`default_nettype none

// A load item writes one 64-bit adjacency row into the row memory. A fetch
// item returns the next graph6 character: a header character or the closing
// newline goes straight to the push state, while a data character first
// gathers its matrix bits (up to six), one row read each, and is then handed
// to the output register. Only one matrix bit is taken from each row read, as
// the row memory has a single read port. in_stall is high while a fetch is
// being worked on; a finished item waits in the output register while the next
// one is accepted. No clearing pass is needed after reset. The vertex count is
// to be written by the user through cfg_we and cfg_wdata only while the block is
// idle; the block itself does not enforce this. Values above 64 act as 64.
module graph6_encoder_unit (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire [6:0]              cfg_wdata,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  g6enc_pkg::g6enc_in_t   in_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output g6enc_pkg::g6enc_out_t  out_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BIT  = 3'b010,
    S_PUSH = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [2:0]            stage_r, stage_nxt;
  logic [6:0]            col_r, col_nxt;
  logic [5:0]            row_r, row_nxt;
  logic [5:0]            acc_r, acc_nxt;
  logic [2:0]            k_r, k_nxt;
  logic [6:0]            vc_r;
  logic                  out_valid_r, out_valid_nxt;
  g6enc_pkg::g6enc_out_t pend_r, pend_nxt;
  g6enc_pkg::g6enc_out_t out_data_r, out_data_nxt;
  logic [63:0]           rd_q_r;
  logic [63:0]           adj_mem [g6enc_pkg::ROW_DEPTH];

  logic        accept;
  logic        mem_we;
  logic        out_free;
  logic [6:0]  n_eff;
  logic [6:0]  row_inc;
  logic        bit_val;
  logic [17:0] n_wide;
  logic [4:0]  grp_shift;
  logic [5:0]  grp;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign n_eff   = (vc_r > 7'(g6enc_pkg::MAX_VERTICES)) ? 7'(g6enc_pkg::MAX_VERTICES) : vc_r;
  assign row_inc = {1'b0, row_r} + 7'd1;
  assign bit_val = rd_q_r[col_r[5:0]];
  assign n_wide  = {11'd0, n_eff};

  always_comb begin
    unique case (stage_r)
      g6enc_pkg::STAGE_GRP_HI:  grp_shift = 5'd12;
      g6enc_pkg::STAGE_GRP_MID: grp_shift = 5'd6;
      default:                  grp_shift = 5'd0;
    endcase
    grp = 6'(n_wide >> grp_shift);
  end

  always_comb begin
    state_nxt = state_r;
    stage_nxt = stage_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    acc_nxt   = acc_r;
    k_nxt     = k_r;
    pend_nxt  = pend_r;
    mem_we    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.command == g6enc_pkg::CMD_LOAD) begin
            mem_we = 1'b1;
          end else begin
            state_nxt          = S_PUSH;
            pend_nxt.last_byte = 1'b0;
            priority if (stage_r == g6enc_pkg::STAGE_HDR0) begin
              if (n_eff <= g6enc_pkg::SHORT_N_MAX) begin
                pend_nxt.out_byte = n_eff + g6enc_pkg::CHAR_OFFSET;
                stage_nxt         = g6enc_pkg::STAGE_DATA;
              end else begin
                pend_nxt.out_byte = g6enc_pkg::CHAR_TILDE;
                stage_nxt         = g6enc_pkg::STAGE_GRP_HI;
              end
            end else if (stage_r >= g6enc_pkg::STAGE_GRP_HI &&
                         stage_r <= g6enc_pkg::STAGE_GRP_LO) begin
              pend_nxt.out_byte = {1'b0, grp} + g6enc_pkg::CHAR_OFFSET;
              stage_nxt = (stage_r == g6enc_pkg::STAGE_GRP_LO) ?
                          g6enc_pkg::STAGE_DATA : stage_r + 3'd1;
            end else if (col_r >= n_eff) begin
              pend_nxt.out_byte  = g6enc_pkg::CHAR_NEWLINE;
              pend_nxt.last_byte = 1'b1;
              stage_nxt          = g6enc_pkg::STAGE_HDR0;
              col_nxt            = 7'd1;
              row_nxt            = 6'd0;
            end else begin
              acc_nxt   = 6'd0;
              k_nxt     = 3'd0;
              state_nxt = S_BIT;
            end
          end
        end
      end
      S_BIT: begin
        acc_nxt = acc_r | (6'(bit_val) << (3'd5 - k_r));
        k_nxt   = k_r + 3'd1;
        if (row_inc >= col_r) begin
          col_nxt = col_r + 7'd1;
          row_nxt = 6'd0;
        end else begin
          row_nxt = row_inc[5:0];
        end
        if (k_r == 3'd5 || col_nxt >= n_eff) begin
          pend_nxt.out_byte  = {1'b0, acc_nxt} + g6enc_pkg::CHAR_OFFSET;
          pend_nxt.last_byte = 1'b0;
          state_nxt          = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (state_r == S_PUSH && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stage_r     <= g6enc_pkg::STAGE_HDR0;
      col_r       <= 7'd1;
      row_r       <= 6'd0;
      vc_r        <= 7'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        vc_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    k_r        <= k_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  // row store: one write, one registered read of the next row to visit
  always_ff @(posedge clk) begin
    if (mem_we) begin
      adj_mem[in_data.row_addr] <= in_data.row_bits;
    end
    rd_q_r <= adj_mem[row_nxt];
  end

  a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last_byte |-> out_data_r.out_byte == g6enc_pkg::CHAR_NEWLINE)
    else $error("last item is not a newline");

  a_data_printable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.last_byte |-> out_data_r.out_byte >= g6enc_pkg::CHAR_OFFSET)
    else $error("non-last item below printable range");

  a_bit_in_triangle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BIT |-> ({1'b0, row_r} < col_r) && (col_r < n_eff) && (k_r <= 3'd5))
    else $error("bit gather outside upper triangle");

  a_fetch_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.command == g6enc_pkg::CMD_FETCH |=> in_stall)
    else $error("fetch did not stall the input");

  a_push_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUSH && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("finished item not moved to output");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// tb_top: self-checking testbench for graph6_encoder_unit, with a clocked driver, a monitor
// and a graph6 predictor that checks every output byte in order
// depends on g6enc_pkg and graph6_encoder_unit
`default_nettype none

module tb_top;

  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned SETTLE_TICKS = 16;
  localparam int unsigned RANDOM_ITEMS = 1000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [6:0]            cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  g6enc_pkg::g6enc_in_t  in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  g6enc_pkg::g6enc_out_t out_data;

  g6enc_pkg::g6enc_in_t  pending_items[$];
  g6enc_pkg::g6enc_out_t expected_chars[$];
  logic [63:0] rows_loaded = '0;

  logic [63:0] row_mem [g6enc_pkg::ROW_DEPTH];
  logic [6:0]  vtx_n;
  logic [2:0]  emit_stage;
  logic [6:0]  col_pos;
  logic [6:0]  row_pos;

  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int          send_calm    = 0;
  int          recv_calm    = 0;

  logic [6:0] wide_counts [8] = '{7'd0, 7'd1, 7'd62, 7'd63, 7'd64, 7'd65, 7'd100, 7'd127};

  graph6_encoder_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit take_break(inout int calm);
    if (calm > 0) begin
      calm--;
      return 1'b0;
    end
    if ($urandom_range(0, 1999) == 0) begin
      calm = $urandom_range(150, 500);
      return 1'b0;
    end
    return $urandom_range(0, 99) < 12;
  endfunction

  function automatic logic [63:0] pick_row_bits();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic next_char(output g6enc_pkg::g6enc_out_t res);
    int unsigned n;
    int unsigned acc;
    int unsigned k;
    int unsigned shift;
    logic [6:0]  ch;
    n = (vtx_n > g6enc_pkg::MAX_VERTICES) ? g6enc_pkg::MAX_VERTICES : vtx_n;
    res.last_byte = 1'b0;
    if (emit_stage == g6enc_pkg::STAGE_HDR0) begin
      if (n <= g6enc_pkg::SHORT_N_MAX) begin
        ch = 7'(n + g6enc_pkg::CHAR_OFFSET);
        emit_stage = g6enc_pkg::STAGE_DATA;
      end else begin
        ch = g6enc_pkg::CHAR_TILDE;
        emit_stage = g6enc_pkg::STAGE_GRP_HI;
      end
    end else if (emit_stage <= g6enc_pkg::STAGE_GRP_LO) begin
      shift = (emit_stage == g6enc_pkg::STAGE_GRP_HI)  ? 12 :
              (emit_stage == g6enc_pkg::STAGE_GRP_MID) ? 6 : 0;
      ch = 7'(((n >> shift) & 32'h3f) + g6enc_pkg::CHAR_OFFSET);
      emit_stage = (emit_stage == g6enc_pkg::STAGE_GRP_LO) ? g6enc_pkg::STAGE_DATA :
                   emit_stage + 3'd1;
    end else if (col_pos >= n) begin
      ch = g6enc_pkg::CHAR_NEWLINE;
      res.last_byte = 1'b1;
      emit_stage = g6enc_pkg::STAGE_HDR0;
      col_pos = 7'd1;
      row_pos = 7'd0;
    end else begin
      acc = 0;
      k = 0;
      while (k < g6enc_pkg::GROUP_BITS && col_pos < n) begin
        acc = (acc << 1) |
              ((row_pos < g6enc_pkg::ROW_DEPTH && col_pos < g6enc_pkg::ROW_WIDTH) ?
               row_mem[row_pos[5:0]][col_pos[5:0]] : 1'b0);
        k++;
        row_pos++;
        if (row_pos >= col_pos) begin
          col_pos++;
          row_pos = 7'd0;
        end
      end
      ch = 7'(((acc << (g6enc_pkg::GROUP_BITS - k)) & 32'h3f) + g6enc_pkg::CHAR_OFFSET);
    end
    res.out_byte = ch;
  endtask

  task automatic push_item(input logic cmd, input logic [5:0] idx, input logic [63:0] bits);
    g6enc_pkg::g6enc_in_t it;
    it.command  = cmd;
    it.row_addr = idx;
    it.row_bits = bits;
    if (cmd == g6enc_pkg::CMD_LOAD) rows_loaded[idx] = 1'b1;
    pending_items.push_back(it);
  endtask

  task automatic push_random(input int count, input int fetch_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < fetch_pct) begin
        push_item(g6enc_pkg::CMD_FETCH, 6'($urandom), pick_row_bits());
      end else begin
        push_item(g6enc_pkg::CMD_LOAD, 6'($urandom), pick_row_bits());
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_chars.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // rows below n-1 are read by the data bytes, so load any that are still unwritten
  task automatic set_vertex_count(input logic [6:0] nv);
    int unsigned n;
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= nv;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n = (nv > g6enc_pkg::MAX_VERTICES) ? g6enc_pkg::MAX_VERTICES : nv;
    for (int r = 0; r + 1 < n; r++) begin
      if (!rows_loaded[r]) push_item(g6enc_pkg::CMD_LOAD, 6'(r), pick_row_bits());
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() != 0 && !take_break(send_calm)) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= take_break(recv_calm);
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    g6enc_pkg::g6enc_out_t got_want;
    g6enc_pkg::g6enc_out_t new_want;
    if (!rst_n) begin
      vtx_n      = 7'd1;
      emit_stage = g6enc_pkg::STAGE_HDR0;
      col_pos    = 7'd1;
      row_pos    = 7'd0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected item, byte %0d", out_data.out_byte));
        end else begin
          got_want = expected_chars.pop_front();
          if (out_data.out_byte !== got_want.out_byte) begin
            report_mismatch($sformatf("out_byte got %0d want %0d",
                                      out_data.out_byte, got_want.out_byte));
          end
          if (out_data.last_byte !== got_want.last_byte) begin
            report_mismatch($sformatf("last_byte got %0b want %0b",
                                      out_data.last_byte, got_want.last_byte));
          end
        end
      end
      if (cfg_we) vtx_n = cfg_wdata;
      if (in_valid && !in_stall) begin
        if (in_data.command == g6enc_pkg::CMD_LOAD) begin
          row_mem[in_data.row_addr] = in_data.row_bits;
        end else begin
          next_char(new_want);
          expected_chars.push_back(new_want);
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int len;
    logic [6:0] nv;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset count of one: header then newline
    push_item(g6enc_pkg::CMD_FETCH, '0, '0);
    push_item(g6enc_pkg::CMD_FETCH, '1, '1);
    // empty graph
    set_vertex_count(7'd0);
    push_item(g6enc_pkg::CMD_FETCH, '0, '0);
    push_item(g6enc_pkg::CMD_FETCH, '0, '0);
    // single edge, padded partial group
    push_item(g6enc_pkg::CMD_LOAD, 6'd0, '1);
    push_item(g6enc_pkg::CMD_LOAD, 6'd63, '0);
    set_vertex_count(7'd2);
    repeat (3) push_item(g6enc_pkg::CMD_FETCH, '0, '0);
    // saturated count, long header, load during encoding
    set_vertex_count(7'd127);
    repeat (6) push_item(g6enc_pkg::CMD_FETCH, '0, '0);
    push_item(g6enc_pkg::CMD_LOAD, 6'd1, 64'h5555_5555_5555_5555);
    repeat (2) push_item(g6enc_pkg::CMD_FETCH, '0, '0);
    // count changed in the middle of an encoding
    set_vertex_count(7'd63);
    repeat (5) push_item(g6enc_pkg::CMD_FETCH, '0, '0);

    // random items, mostly fetches, at the largest size
    set_vertex_count(7'd64);
    push_random(400, 92);
    sent = 400;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        nv  = wide_counts[$urandom_range(0, 7)];
        len = $urandom_range(30, 120);
      end else begin
        nv  = 7'($urandom_range(2, 14));
        len = $urandom_range(20, 60);
      end
      set_vertex_count(nv);
      push_random(len, 80);
      sent += len;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/core/g6enc_pkg.sv
rtl/core/graph6_encoder_unit.sv
tb/sv/tb_top.sv
